[src/gb3_pkg.sv]
package gb3_pkg;

    // Largest image row that the line store holds.
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    // Column counts up to and including MAX_WIDTH.
    localparam int COL_W = ADDR_W + 1;
    localparam int ROW_W = 12;
    localparam int CFG_W = 12;
    localparam int CH_W = 8;
    localparam int PIX_W = 3 * CH_W;
    // Weighted sum of nine taps with total weight 16.
    localparam int SUM_W = CH_W + 4;

    // Queue between front and back; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Reciprocals for the edge and corner divisors, scaled by 2**RECIP_SHIFT.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_12 = 5462;
    localparam int RECIP_9 = 7282;

    localparam logic REG_FRAME_WIDTH = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        DIV_16,
        DIV_12,
        DIV_9
    } gb3_div_t;

    typedef struct packed {
        logic            opcode;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] red_in;
    } gb3_in_t;

    typedef struct packed {
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] red_out;
        logic            frame_last;
    } gb3_out_t;

    typedef struct packed {
        logic [COL_W-1:0] width;
        logic [ROW_W-1:0] height;
    } gb3_size_t;

    typedef struct packed {
        logic due;
        logic no_left;
        logic no_right;
        logic no_top;
        logic no_bottom;
        logic last;
    } gb3_tag_t;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
        logic [PIX_W-1:0] bottom;
        gb3_tag_t         tag;
    } gb3_entry_t;

endpackage

[src/gb3_ram.sv]
module gb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/gb3_front.sv]
module gb3_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  gb3_pkg::gb3_in_t          in_data,
    input  gb3_pkg::gb3_size_t        size,
    input  logic [gb3_pkg::QCNT_W-1:0] q_level,
    output logic                      push_valid,
    output gb3_pkg::gb3_entry_t       push_data
);

    import gb3_pkg::*;

    logic [ADDR_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [ADDR_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [PIX_W-1:0]  s1_bot_reg;
    gb3_tag_t          s1_tag_reg;

    logic [ADDR_W-1:0] ic, oc;
    logic [COL_W-1:0]  ic_inc;
    logic              flush, drop, accept, issue;
    logic              due, right_edge, at_bottom, last;
    logic [QCNT_W:0]   occupancy;
    logic [PIX_W-1:0]  bot;
    logic [2*PIX_W-1:0] ram_rdata;
    gb3_tag_t          tag;

    // Room is counted for the item in the read stage, which always pushes.
    assign occupancy = (QCNT_W+1)'(q_level) + (QCNT_W+1)'(s1_valid_reg);
    assign in_ready = occupancy < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept = in_valid && in_ready;

    always_comb
    begin
        ic = ({1'b0, in_col_reg} >= size.width) ? '0 : in_col_reg;
        oc = ({1'b0, out_col_reg} >= size.width) ? '0 : out_col_reg;
        ic_inc = {1'b0, ic} + COL_W'(1);
        flush = in_row_reg >= size.height;
        drop = !flush && (in_data.opcode == OP_DRAIN);
        issue = accept && !drop;
        bot = flush ? '0 : {in_data.red_in, in_data.green_in, in_data.blue_in};
        due = (in_row_reg >= ROW_W'(2)) || ((in_row_reg == ROW_W'(1)) && (ic != '0));
        right_edge = {1'b0, oc} >= (size.width - COL_W'(1));
        at_bottom = out_row_reg >= (size.height - ROW_W'(1));
        last = due && at_bottom && right_edge;

        tag.due = due;
        tag.no_left = (oc == '0);
        tag.no_right = right_edge;
        tag.no_top = (out_row_reg == '0);
        tag.no_bottom = at_bottom;
        tag.last = last;

        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept)
        begin
            if (drop)
            begin
                in_col_next = ic;
                out_col_next = oc;
            end
            else if (last)
            begin
                in_col_next = '0;
                in_row_next = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                out_col_next = oc;
                if (due)
                begin
                    if (right_edge)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        out_col_next = oc + ADDR_W'(1);
                    end
                end
                if (ic_inc >= size.width)
                begin
                    in_col_next = '0;
                    if (!flush)
                    begin
                        in_row_next = in_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    in_col_next = ic_inc[ADDR_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_addr_reg <= ic;
            s1_bot_reg <= bot;
            s1_tag_reg <= tag;
        end
    end

    // One word per column holds both stored rows; the column is read when the
    // pixel arrives and rewritten in the next cycle, shifted up by one row.
    gb3_ram #(
        .WIDTH(2 * PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata ({ram_rdata[PIX_W-1:0], s1_bot_reg}),
        .re    (issue),
        .raddr (ic),
        .rdata (ram_rdata)
    );

    assign push_valid = s1_valid_reg;
    assign push_data.upper = ram_rdata[2*PIX_W-1:PIX_W];
    assign push_data.middle = ram_rdata[PIX_W-1:0];
    assign push_data.bottom = s1_bot_reg;
    assign push_data.tag = s1_tag_reg;

endmodule

[src/gb3_fifo.sv]
module gb3_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_valid,
    input  gb3_pkg::gb3_entry_t        push_data,
    output logic [gb3_pkg::QCNT_W-1:0] level,
    output logic                       pop_valid,
    input  logic                       pop_ready,
    output gb3_pkg::gb3_entry_t        pop_data
);

    import gb3_pkg::*;

    gb3_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    assign pop_valid = count_reg != '0;
    assign pop = pop_valid && pop_ready;
    assign pop_data = slot_reg[rd_ptr_reg];
    assign level = count_reg;

    always_comb
    begin
        wr_ptr_next = push_valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next = count_reg + QCNT_W'(push_valid) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/gb3_back.sv]
module gb3_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  gb3_pkg::gb3_entry_t pop_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gb3_pkg::gb3_out_t   out_data
);

    import gb3_pkg::*;

    function automatic logic [CH_W-1:0] divide(input logic [SUM_W-1:0] s, input gb3_div_t d);
        logic [SUM_W+RECIP_SHIFT-1:0] prod;
        logic [CH_W-1:0]              q;
        begin
            prod = '0;
            case (d)
                DIV_16:
                begin
                    q = s[SUM_W-1:4];
                end
                DIV_12:
                begin
                    prod = (SUM_W+RECIP_SHIFT)'(s) * (SUM_W+RECIP_SHIFT)'(RECIP_12);
                    q = prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
                end
                default:
                begin
                    prod = (SUM_W+RECIP_SHIFT)'(s) * (SUM_W+RECIP_SHIFT)'(RECIP_9);
                    q = prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
                end
            endcase
            return q;
        end
    endfunction

    logic [PIX_W-1:0] win_reg [3][3];
    logic [PIX_W-1:0] win_next [3][3];

    logic             b1_valid_reg;
    logic [SUM_W-1:0] b1_sum_reg [3];
    gb3_div_t         b1_div_reg;
    logic             b1_last_reg;

    logic             out_valid_reg;
    gb3_out_t         out_data_reg;

    logic             b1_load, b2_load, take;
    logic [SUM_W-1:0] sum [3];
    logic [2:0]       masked;
    gb3_div_t         div_sel;

    assign b2_load = !out_valid_reg || out_ready;
    assign b1_load = !b1_valid_reg || b2_load;
    assign pop_ready = b1_load;
    assign take = pop_valid && pop_ready;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = pop_data.upper;
        win_next[1][2] = pop_data.middle;
        win_next[2][2] = pop_data.bottom;

        // Taps outside the frame drop out of both the sum and the divisor.
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (!((r == 0 && pop_data.tag.no_top) ||
                          (r == 2 && pop_data.tag.no_bottom) ||
                          (c == 0 && pop_data.tag.no_left) ||
                          (c == 2 && pop_data.tag.no_right)))
                    begin
                        sum[ch] = sum[ch] + (SUM_W'(win_next[r][c][CH_W*ch +: CH_W])
                            << ((r == 1 ? 1 : 0) + (c == 1 ? 1 : 0)));
                    end
                end
            end
        end

        masked = 3'(pop_data.tag.no_left) + 3'(pop_data.tag.no_right)
               + 3'(pop_data.tag.no_top) + 3'(pop_data.tag.no_bottom);
        case (masked)
            3'd0:    div_sel = DIV_16;
            3'd1:    div_sel = DIV_12;
            default: div_sel = DIV_9;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
            b1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                win_reg <= win_next;
            end
            if (b1_load)
            begin
                b1_valid_reg <= take && pop_data.tag.due;
            end
            if (b2_load)
            begin
                out_valid_reg <= b1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_load && take)
        begin
            b1_sum_reg <= sum;
            b1_div_reg <= div_sel;
            b1_last_reg <= pop_data.tag.last;
        end
        if (b2_load && b1_valid_reg)
        begin
            out_data_reg.blue_out <= divide(b1_sum_reg[0], b1_div_reg);
            out_data_reg.green_out <= divide(b1_sum_reg[1], b1_div_reg);
            out_data_reg.red_out <= divide(b1_sum_reg[2], b1_div_reg);
            out_data_reg.frame_last <= b1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

[src/gaussian_blur_3x3_rgb.sv]
// Streaming 3x3 Gaussian blur (1-2-1 / 2-4-2 / 1-2-1) of RGB pixels in raster order. The block
// takes one request per clock and gives one blurred pixel per clock while out_ready is high and
// the queue has room; the rate is set by the single-port-per-direction line RAM, which is read
// when a pixel arrives and rewritten with the shifted rows in the next cycle. The blurred pixel
// for input k is computed from input k + frame_width + 1 and passes the read stage, queue, sum
// and output registers; after the last pixel of a frame, frame_width + 1 drain requests (opcode
// 1, or pixels, whose color is then dropped) flush the rest, and the final pixel carries
// frame_last. A drain request inside a frame is dropped. Edge pixels divide by 12 and corners by
// 9, truncating. The line RAM is not cleared after reset; its unwritten words only feed taps
// outside the frame. Program frame_width and frame_height only while the block is idle.
module gaussian_blur_3x3_rgb (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  gb3_pkg::gb3_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output gb3_pkg::gb3_out_t          out_data,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [gb3_pkg::CFG_W-1:0]  cfg_data
);

    import gb3_pkg::*;

    logic [CFG_W-1:0]  frame_width_reg;
    logic [CFG_W-1:0]  frame_height_reg;
    gb3_size_t         size;
    logic [QCNT_W-1:0] q_level;
    logic              push_valid, pop_valid, pop_ready;
    gb3_entry_t        push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= CFG_W'(640);
            frame_height_reg <= CFG_W'(480);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_width_reg <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg < CFG_W'(2))
        begin
            size.width = COL_W'(2);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            size.width = COL_W'(MAX_WIDTH);
        end
        else
        begin
            size.width = COL_W'(frame_width_reg);
        end
        size.height = (frame_height_reg < CFG_W'(2)) ? ROW_W'(2) : ROW_W'(frame_height_reg);
    end

    gb3_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .size       (size),
        .q_level    (q_level),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    gb3_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .level      (q_level),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    gb3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[src/gb3_checker.sv]
module gb3_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input gb3_pkg::gb3_in_t          in_data,
    input logic                      out_valid,
    input logic                      out_ready,
    input gb3_pkg::gb3_out_t         out_data,
    input logic                      cfg_we,
    input logic                      cfg_index,
    input logic [gb3_pkg::CFG_W-1:0] cfg_data
);

    // A result waiting on the output keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // Reset empties the pipeline and opens the input.
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid && in_ready)
        else $error("pipeline not empty in reset");

    // The queue can only fill up right after a request was taken.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && in_ready))
        else $error("input stalled without a new request");

endmodule

bind gaussian_blur_3x3_rgb gb3_checker u_gb3_checker (.*);

[test/tb_gaussian_blur_3x3_rgb.sv]
`timescale 1ns / 100ps

module tb_gaussian_blur_3x3_rgb;
    import gb3_pkg::*;

    // Behavioral copy of the blur pipeline; tracks the expected pixel stream.
    class blur_scoreboard;
        logic [PIX_W-1:0] row_upper [MAX_WIDTH];
        logic [PIX_W-1:0] row_middle [MAX_WIDTH];
        logic [PIX_W-1:0] win [9];
        int unsigned col_in, row_in, col_out, row_out;
        int unsigned cfg_width, cfg_height;
        gb3_out_t pending_pixels [$];
        int errors;

        function void clear();
            foreach (win[i]) win[i] = '0;
            foreach (row_upper[i]) row_upper[i] = '0;
            foreach (row_middle[i]) row_middle[i] = '0;
            col_in = 0; row_in = 0; col_out = 0; row_out = 0;
            cfg_width = 640; cfg_height = 480;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == REG_FRAME_WIDTH)
                cfg_width = 32'(value);
            else
                cfg_height = 32'(value);
        endfunction

        function gb3_out_t weigh(int lc, int cc, int rc, bit nl, bit nr, bit nt, bit nb);
            int cols [3];
            int wsum;
            int sums [3];
            int w;
            logic [PIX_W-1:0] p;
            gb3_out_t res;
            cols[0] = lc; cols[1] = cc; cols[2] = rc;
            wsum = 0;
            sums[0] = 0; sums[1] = 0; sums[2] = 0;
            for (int r = 0; r < 3; r++) begin
                if ((r == 0 && nt) || (r == 2 && nb))
                    continue;
                for (int c = 0; c < 3; c++) begin
                    if ((c == 0 && nl) || (c == 2 && nr))
                        continue;
                    w = (r == 1 ? 2 : 1) * (c == 1 ? 2 : 1);
                    p = win[r * 3 + cols[c]];
                    wsum += w;
                    for (int ch = 0; ch < 3; ch++)
                        sums[ch] += w * p[8 * ch +: 8];
                end
            end
            res = '0;
            res.blue_out = CH_W'(sums[0] / wsum);
            res.green_out = CH_W'(sums[1] / wsum);
            res.red_out = CH_W'(sums[2] / wsum);
            return res;
        endfunction

        function void note_request(gb3_in_t req);
            int unsigned wd, ht, x;
            bit flushing, due, edge_r, last;
            logic [PIX_W-1:0] bot;
            gb3_out_t res;
            wd = cfg_width < 2 ? 2 : (cfg_width > MAX_WIDTH ? MAX_WIDTH : cfg_width);
            ht = cfg_height < 2 ? 2 : cfg_height;
            if (col_in >= wd) col_in = 0;
            if (col_out >= wd) col_out = 0;
            flushing = row_in >= ht;
            if (!flushing && req.opcode == OP_DRAIN)
                return;
            bot = flushing ? '0 : {req.red_in, req.green_in, req.blue_in};
            x = col_in;
            due = row_in >= 2 || (row_in == 1 && x >= 1);
            edge_r = col_out >= wd - 1;
            if (due && edge_r)
                res = weigh(1, 2, 2, 0, 1, row_out == 0, row_out >= ht - 1);
            for (int r = 0; r < 3; r++) begin
                win[r * 3] = win[r * 3 + 1];
                win[r * 3 + 1] = win[r * 3 + 2];
            end
            win[2] = row_upper[x];
            win[5] = row_middle[x];
            win[8] = bot;
            row_upper[x] = row_middle[x];
            row_middle[x] = bot;
            if (due && !edge_r)
                res = weigh(0, 1, 2, col_out == 0, 0, row_out == 0, row_out >= ht - 1);
            if (due) begin
                last = row_out >= ht - 1 && edge_r;
                res.frame_last = last;
                pending_pixels = {pending_pixels, res};
                if (last) begin
                    col_in = 0; row_in = 0; col_out = 0; row_out = 0;
                    return;
                end
                if (edge_r) begin
                    col_out = 0;
                    row_out = (row_out + 1) & 12'hFFF;
                end
                else begin
                    col_out++;
                end
            end
            col_in++;
            if (col_in >= wd) begin
                col_in = 0;
                if (!flushing) row_in++;
            end
        endfunction

        function void check_pixel(gb3_out_t got);
            gb3_out_t exp_px;
            if (pending_pixels.size() == 0) begin
                $error("unexpected output pixel %h", got);
                errors++;
                return;
            end
            exp_px = pending_pixels.pop_front();
            if (got.blue_out !== exp_px.blue_out) begin
                $error("blue_out: expected %0d, got %0d", exp_px.blue_out, got.blue_out);
                errors++;
            end
            if (got.green_out !== exp_px.green_out) begin
                $error("green_out: expected %0d, got %0d", exp_px.green_out, got.green_out);
                errors++;
            end
            if (got.red_out !== exp_px.red_out) begin
                $error("red_out: expected %0d, got %0d", exp_px.red_out, got.red_out);
                errors++;
            end
            if (got.frame_last !== exp_px.frame_last) begin
                $error("frame_last: expected %0d, got %0d", exp_px.frame_last,
                       got.frame_last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    gb3_in_t in_data;
    logic out_valid;
    logic out_ready;
    gb3_out_t out_data;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    blur_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;

    gaussian_blur_3x3_rgb DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // Receiver side: random stalls, every accepted pixel checked.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_pixel(out_data);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Valid is dropped only while idling, so back-to-back requests keep it high.
    task automatic send_request(logic op, logic [PIX_W-1:0] rgb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= {op, rgb[7:0], rgb[15:8], rgb[23:16]};
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(in_data);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] rand_rgb();
        return PIX_W'($urandom);
    endfunction

    // One whole frame of pixels, then the drains that flush it; stray drains are slipped in
    // before a few pixels, and a few drains are swapped for flush-time pixels.
    task automatic run_frame(int wd, int ht, bit noisy);
        for (int i = 0; i < wd * ht; i++) begin
            if (noisy && $urandom_range(9) == 0)
                send_request(OP_DRAIN, rand_rgb());
            send_request(OP_PIXEL, rand_rgb());
        end
        for (int i = 0; i <= wd; i++)
            send_request((noisy && $urandom_range(3) == 0) ? OP_PIXEL : OP_DRAIN, rand_rgb());
    endtask

    initial
    begin
        int sent;
        int wd;
        int ht;
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        send_idle_pct = 36;
        recv_idle_pct = 52;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: smallest frame with extreme colors, a stray drain, a flush pixel.
        write_reg(REG_FRAME_WIDTH, CFG_W'(2));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
        send_request(OP_DRAIN, 24'h123456);
        send_request(OP_PIXEL, 24'hFFFFFF);
        send_request(OP_PIXEL, 24'h000000);
        send_request(OP_PIXEL, 24'hFF00FF);
        send_request(OP_PIXEL, 24'hFFFFFF);
        send_request(OP_PIXEL, 24'hAAAAAA);
        send_request(OP_DRAIN, 24'h0);
        send_request(OP_DRAIN, 24'h0);
        wait_idle();
        // Out-of-range sizes act as the limits.
        write_reg(REG_FRAME_WIDTH, CFG_W'(0));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
        for (int i = 0; i < 4; i++)
            send_request(OP_PIXEL, i[0] ? 24'hFFFFFF : 24'h555555);
        for (int i = 0; i < 3; i++)
            send_request(OP_DRAIN, 24'h0);
        wait_idle();

        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 36 : (phase == 1 ? 52 : 0);
            recv_idle_pct = phase == 0 ? 52 : (phase == 1 ? 36 : 0);
            while (sent < 210 * (phase + 1)) begin
                wd = ($urandom_range(7) == 0) ? $urandom_range(2, 12) : $urandom_range(2, 5);
                ht = $urandom_range(2, 6);
                write_reg(REG_FRAME_WIDTH, CFG_W'(wd));
                write_reg(REG_FRAME_HEIGHT, CFG_W'(ht));
                run_frame(wd, ht, $urandom_range(3) == 0);
                sent += wd * ht + wd + 1;
                wait_idle();
            end
        end

        // Largest height register value on a narrow frame, kept short.
        write_reg(REG_FRAME_WIDTH, CFG_W'(3));
        write_reg(REG_FRAME_HEIGHT, 12'hFFF);
        for (int i = 0; i < 9; i++)
            send_request(OP_PIXEL, rand_rgb());
        wait_idle();

        if (sb.errors == 0 && sb.pending_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
